// File: src/msh_pkg.sv
// ----------------------------------------------------------------------------
// msh_pkg: shared types and constants for the half-step stepper sequencer
// Request and result payloads, the per-motor state entry, operation codes
// and the half-step coil pattern table.
// ----------------------------------------------------------------------------
package msh_pkg;

    // Ramp start period after reset, before division by the motor count
    localparam logic [7:0] START_PERIOD_RST = 8'd20;

    // Default motor count
    localparam int NUM_MOTORS_DEF = 2;

    // Operation codes; the unused code behaves as a status query
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]          operation;
        logic                motor;
        logic signed [15:0]  step_count;
        logic [7:0]          speed;
    } t_req;

    typedef struct packed {
        logic                served_motor;
        logic [3:0]          coil_pattern;
        logic                coil_write;
        logic                coil_off;
        logic                busy_res;
        logic signed [15:0]  position;
        logic signed [15:0]  steps_left;
    } t_res;

    // State kept for one motor
    typedef struct packed {
        logic        enabled;
        logic [15:0] remaining_steps;
        logic [15:0] step_position;
        logic [7:0]  period_counter;
        logic [7:0]  current_period;
        logic [7:0]  target_period;
        logic [2:0]  phase_index;
    } t_entry;

    // Half-step sequence A, AB, B, BC, C, CD, D, DA (bit0 = coil A)
    function automatic logic [3:0] coil_pattern_of(input logic [2:0] phase);
        logic [3:0] pat;
        case (phase)
            3'd0:    pat = 4'h1;
            3'd1:    pat = 4'h3;
            3'd2:    pat = 4'h2;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h4;
            3'd5:    pat = 4'hC;
            3'd6:    pat = 4'h8;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

endpackage

// File: src/msh_state_mem.sv
// ----------------------------------------------------------------------------
// msh_state_mem: per-motor state memory
// One synchronous memory entry per motor with a registered read. Entries
// never written since reset read as the reset state; a write landing on
// the address being read in the same cycle is forwarded.
// ----------------------------------------------------------------------------
module msh_state_mem
    import msh_pkg::*;
#(
    parameter int NUM_MOTORS = NUM_MOTORS_DEF,
    parameter int MW         = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [MW-1:0] i_rd_addr,
    output t_entry        o_rd_data,
    input  logic          i_wr_en,
    input  logic [MW-1:0] i_wr_addr,
    input  t_entry        i_wr_data
);

    localparam logic [7:0] RESET_DIV = 8'(START_PERIOD_RST / NUM_MOTORS);

    t_entry                  r_mem [NUM_MOTORS];
    logic [NUM_MOTORS-1:0]   r_vld;
    t_entry                  r_rd;
    logic                    r_rd_vld;
    logic                    r_byp;
    t_entry                  r_byp_data;
    t_entry                  rst_entry;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Track written entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Registered read; hold while no new read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd       <= r_mem[i_rd_addr];
            r_rd_vld   <= r_vld[i_rd_addr];
            r_byp_data <= i_wr_data;
        end
    end

    // Forward a write that hits the address read in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_rd_en) begin
            r_byp <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_comb begin
        rst_entry                = '0;
        rst_entry.current_period = RESET_DIV;
        rst_entry.target_period  = RESET_DIV;
    end

    assign o_rd_data = r_byp ? r_byp_data : (r_rd_vld ? r_rd : rst_entry);

endmodule

// File: src/multi_stepper_halfstep_ramp.sv
// ----------------------------------------------------------------------------
// multi_stepper_halfstep_ramp: time-multiplexed half-step stepper sequencer
// Serves NUM_MOTORS four-coil motors from one state memory with a ramped
// step period, signed move counts and wrapping positions.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_in_valid/i_in_req and are taken at an edge where
//   o_in_stall is low. Each request yields exactly one result on
//   o_out_valid/o_out_res, taken at an edge where i_out_stall is low.
//   Operations: tick (serve next motor round robin), start move, status.
//   A request passes stage 1 and the output register; one request is taken
//   every cycle while the receiver does not stall. Each request reads its
//   motor's entry from the state memory, updates it and writes it back as
//   it leaves stage 1; back-to-back requests to the same motor are forwarded.
//   i_cfg_we/i_cfg_wdata write the ramp start period; write it only
//   while no request is in flight.
//   Synchronous reset (i_rst_n low) empties the pipeline, points the
//   service pointer at motor 0 and returns all motor state to its reset
//   values at once; no clearing pass is needed.
//   When the receiver stalls, the result is held and one more request is
//   absorbed; after that o_in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module multi_stepper_halfstep_ramp
    import msh_pkg::*;
#(
    parameter int NUM_MOTORS = NUM_MOTORS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_req       i_in_req,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_res       o_out_res
);

    localparam int          MW    = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam logic [16:0] RECIP = 17'((65536 + NUM_MOTORS - 1) / NUM_MOTORS);
    localparam logic [MW-1:0] LAST_MOTOR = MW'(NUM_MOTORS - 1);

    // Configuration and service pointer
    logic [7:0]    r_start_div;
    logic [MW-1:0] r_sp;
    logic [MW-1:0] n_sp;

    // Stage 1: request waiting for its memory read
    logic          r_s1_vld;
    logic [1:0]    r_s1_op;
    logic          r_s1_motor;
    logic          r_s1_inrange;
    logic [MW-1:0] r_s1_addr;
    logic [15:0]   r_s1_count;
    logic [7:0]    r_s1_tgt;

    // Output register
    logic          r_out_vld;
    t_res          r_out_res;
    t_res          n_out_res;

    logic          out_free;
    logic          s1_adv;
    logic          acc;
    logic          in_tick;
    logic          in_range;
    logic [MW-1:0] rd_addr;
    logic [24:0]   cfg_prod;
    logic [24:0]   spd_prod;

    t_entry        cur;
    t_entry        upd;
    logic          wr_en;
    logic          s1_tick;
    logic          s1_start;
    logic [7:0]    cnt_inc;

    // Handshake
    assign out_free   = !r_out_vld || !i_out_stall;
    assign s1_adv     = r_s1_vld && out_free;
    assign o_in_stall = r_s1_vld && !out_free;
    assign acc        = i_in_valid && !o_in_stall;
    assign in_tick    = (i_in_req.operation == OP_TICK);
    assign in_range   = ({31'b0, i_in_req.motor} < 32'(NUM_MOTORS));
    assign rd_addr    = in_tick ? r_sp : MW'(i_in_req.motor);

    // Divide by the motor count through a reciprocal multiply
    assign cfg_prod = 25'(i_cfg_wdata) * 25'(RECIP);
    assign spd_prod = 25'(i_in_req.speed) * 25'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_div <= 8'(START_PERIOD_RST / NUM_MOTORS);
        end else if (i_cfg_we) begin
            r_start_div <= cfg_prod[23:16];
        end
    end

    // Advance the service pointer on each accepted tick
    assign n_sp = (r_sp == LAST_MOTOR) ? '0 : r_sp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else if (acc && in_tick) begin
            r_sp <= n_sp;
        end
    end

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_op      <= i_in_req.operation;
            r_s1_motor   <= i_in_req.motor;
            r_s1_inrange <= in_range;
            r_s1_addr    <= rd_addr;
            r_s1_count   <= i_in_req.step_count;
            r_s1_tgt     <= spd_prod[23:16];
        end
    end

    msh_state_mem #(
        .NUM_MOTORS (NUM_MOTORS),
        .MW         (MW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (acc),
        .i_rd_addr (rd_addr),
        .o_rd_data (cur),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (upd)
    );

    // Update the motor entry and build the result
    assign s1_tick  = (r_s1_op == OP_TICK);
    assign s1_start = (r_s1_op == OP_START) && r_s1_inrange;
    assign cnt_inc  = cur.period_counter + 8'd1;
    assign wr_en    = s1_adv && (s1_tick || s1_start);

    always_comb begin
        upd       = cur;
        n_out_res = '0;
        case (r_s1_op)
            OP_TICK: begin
                n_out_res.served_motor = r_s1_addr[0];
                if (cur.enabled) begin
                    upd.period_counter = cnt_inc;
                    if (cnt_inc >= cur.current_period) begin
                        upd.period_counter = '0;
                        if (cur.current_period > cur.target_period) begin
                            upd.current_period = cur.current_period - 8'd1;
                        end
                        if (cur.remaining_steps != '0) begin
                            if (!cur.remaining_steps[15]) begin
                                upd.phase_index     = cur.phase_index + 3'd1;
                                upd.remaining_steps = cur.remaining_steps - 16'd1;
                                upd.step_position   = cur.step_position + 16'd1;
                            end else begin
                                upd.phase_index     = cur.phase_index - 3'd1;
                                upd.remaining_steps = cur.remaining_steps + 16'd1;
                                upd.step_position   = cur.step_position - 16'd1;
                            end
                            n_out_res.coil_write   = 1'b1;
                            n_out_res.coil_pattern = coil_pattern_of(upd.phase_index);
                        end else begin
                            upd.enabled = 1'b0;
                        end
                    end
                end else begin
                    n_out_res.coil_off = 1'b1;
                end
                n_out_res.busy_res   = upd.enabled;
                n_out_res.position   = upd.step_position;
                n_out_res.steps_left = upd.remaining_steps;
            end
            default: begin
                n_out_res.served_motor = r_s1_motor;
                if (s1_start) begin
                    upd.enabled         = 1'b1;
                    upd.remaining_steps = r_s1_count;
                    upd.target_period   = r_s1_tgt;
                    upd.current_period  = r_start_div;
                end
                if (r_s1_inrange) begin
                    n_out_res.busy_res   = upd.enabled;
                    n_out_res.position   = upd.step_position;
                    n_out_res.steps_left = upd.remaining_steps;
                end
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_res <= n_out_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_res   = r_out_res;

    // Checks
    a_write_not_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_res.coil_write |-> !r_out_res.coil_off)
        else $error("coil write and coil off in one result");

    a_pattern_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out_res.coil_write |-> r_out_res.coil_pattern == 4'h0)
        else $error("coil pattern without coil write");

    a_off_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_res.coil_off |-> !r_out_res.busy_res)
        else $error("coil off reported for busy motor");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !out_free |=> r_s1_vld && $stable(r_s1_addr))
        else $error("stalled request dropped from stage 1");

    a_sp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && in_tick |=> r_sp == $past(n_sp))
        else $error("service pointer did not advance on tick");

endmodule

// File: verif/multi_stepper_halfstep_ramp_tb.sv
// ----------------------------------------------------------------------------
// multi_stepper_halfstep_ramp_tb: self-checking bench for the stepper sequencer
// Replays directed and random tick, start and status requests against a
// cycle-free model of the motor table, with random gaps on both handshakes
// and several ramp start periods, and checks every result field by field.
// ----------------------------------------------------------------------------
module multi_stepper_halfstep_ramp_tb;
    import msh_pkg::*;

    localparam int MOTORS = NUM_MOTORS_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_REQUESTS = 105;
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Half-step coil sequence A, AB, B, BC, C, CD, D, DA
    localparam logic [3:0] HALF_STEP [8] = '{4'h1, 4'h3, 4'h2, 4'h6,
                                             4'h4, 4'hC, 4'h8, 4'h9};

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [7:0] cfg_wdata = '0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_req       in_req = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_res       out_res;

    // Motor table mirror
    logic        m_enabled [MOTORS];
    logic [15:0] m_remain  [MOTORS];
    logic [15:0] m_pos     [MOTORS];
    logic [7:0]  m_count   [MOTORS];
    logic [7:0]  m_period  [MOTORS];
    logic [7:0]  m_target  [MOTORS];
    logic [2:0]  m_phase   [MOTORS];
    int unsigned svc_ptr;
    logic [7:0]  ramp_start;

    t_res pending_results [$];

    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int stall_left = 0;
    int idle_cycles = 0;
    int mismatches = 0;
    int requests_sent = 0;
    int coil_steps = 0;
    int settings_used = 1;

    multi_stepper_halfstep_ramp #(
        .NUM_MOTORS(MOTORS)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_res   (out_res)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Return the motor table to its power-up contents
    function automatic void clear_motor_table();
        ramp_start = START_PERIOD_RST;
        for (int i = 0; i < MOTORS; i++) begin
            m_enabled[i] = 1'b0;
            m_remain[i]  = '0;
            m_pos[i]     = '0;
            m_count[i]   = '0;
            m_period[i]  = 8'(ramp_start / MOTORS);
            m_target[i]  = 8'(ramp_start / MOTORS);
            m_phase[i]   = '0;
        end
        svc_ptr = 0;
    endfunction

    // Apply one request to the motor table and return the result it yields
    function automatic t_res advance_motors(input t_req r);
        t_res res;
        int unsigned m;
        res = '0;
        if (r.operation == OP_TICK) begin
            m = (svc_ptr >= MOTORS) ? 0 : svc_ptr;
            if (m_enabled[m]) begin
                m_count[m] = m_count[m] + 8'd1;
                if (m_count[m] >= m_period[m]) begin
                    m_count[m] = '0;
                    if (m_period[m] > m_target[m])
                        m_period[m] = m_period[m] - 8'd1;
                    if (m_remain[m] != '0) begin
                        // step toward zero remaining, direction from the sign
                        if (!m_remain[m][15]) begin
                            m_phase[m]  = m_phase[m] + 3'd1;
                            m_remain[m] = m_remain[m] - 16'd1;
                            m_pos[m]    = m_pos[m] + 16'd1;
                        end else begin
                            m_phase[m]  = m_phase[m] - 3'd1;
                            m_remain[m] = m_remain[m] + 16'd1;
                            m_pos[m]    = m_pos[m] - 16'd1;
                        end
                        res.coil_write   = 1'b1;
                        res.coil_pattern = HALF_STEP[m_phase[m]];
                    end else begin
                        m_enabled[m] = 1'b0;
                    end
                end
            end else begin
                res.coil_off = 1'b1;
            end
            res.served_motor = m[0];
            res.busy_res     = m_enabled[m];
            res.position     = m_pos[m];
            res.steps_left   = m_remain[m];
            svc_ptr = (m + 1 >= MOTORS) ? 0 : m + 1;
        end else begin
            res.served_motor = r.motor;
            if (int'(r.motor) < MOTORS) begin
                if (r.operation == OP_START) begin
                    m_enabled[r.motor] = 1'b1;
                    m_remain[r.motor]  = r.step_count;
                    m_target[r.motor]  = 8'(r.speed / MOTORS);
                    m_period[r.motor]  = 8'(ramp_start / MOTORS);
                end
                res.busy_res   = m_enabled[r.motor];
                res.position   = m_pos[r.motor];
                res.steps_left = m_remain[r.motor];
            end
        end
        return res;
    endfunction

    function automatic t_req make_req(input logic [1:0] op, input logic motor,
                                      input int count, input int speed);
        t_req r;
        r.operation  = op;
        r.motor      = motor;
        r.step_count = 16'(count);
        r.speed      = 8'(speed);
        return r;
    endfunction

    // Draw a request: mostly ticks and short moves, some full-range noise
    function automatic t_req random_request();
        t_req r;
        int sel;
        int count;
        int speed;
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            r = t_req'($urandom);
        end else if (sel < 68) begin
            r = make_req(OP_TICK, 1'($urandom), $urandom, $urandom);
        end else if (sel < 84) begin
            if ($urandom_range(0, 4) == 0)
                count = $urandom;
            else
                count = int'($urandom_range(0, 16)) - 8;
            speed = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, 12);
            r = make_req(OP_START, 1'($urandom), count, speed);
        end else begin
            r = make_req(($urandom_range(0, 3) == 0) ? OP_SPARE : OP_QUERY,
                         1'($urandom), $urandom, $urandom);
        end
        return r;
    endfunction

    // Offer one request, after a random gap unless pacing is steady, and hold it until taken
    task automatic send_request(input t_req r);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(advance_motors(r));
        requests_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_request(make_req(OP_TICK, 1'b0, 0, 0));
    endtask

    // Drop valid and hold until every pending result has drained
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_ramp_start(input logic [7:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        ramp_start = value;
        settings_used++;
    endtask

    // Reset state, coils-off ticks, spare opcode, zero period and field extremes
    task automatic test_directed();
        send_request(make_req(OP_QUERY, 1'b0, 0, 0));
        send_request(make_req(OP_QUERY, 1'b1, -1, 255));
        send_request(make_req(OP_SPARE, 1'b1, 0, 0));
        send_ticks(2);
        write_ramp_start(8'd0);
        send_request(make_req(OP_START, 1'b0, 3, 0));
        send_request(make_req(OP_START, 1'b1, -2, 255));
        send_ticks(8);
        send_request(make_req(OP_START, 1'b0, 32767, 255));
        send_request(make_req(OP_START, 1'b1, -32768, 0));
        send_ticks(4);
        send_request(make_req(OP_START, 1'b0, 0, 0));
        send_ticks(2);
    endtask

    // Period ramps down one tick per step from the start period to the target
    task automatic test_accel_ramp();
        write_ramp_start(8'd16);
        send_request(make_req(OP_START, 1'b0, 10, 0));
        send_request(make_req(OP_START, 1'b1, -10, 2));
        send_ticks(45);
        send_request(make_req(OP_QUERY, 1'b0, 0, 0));
        send_ticks(45);
        send_request(make_req(OP_QUERY, 1'b1, 0, 0));
    endtask

    // Random traffic in phases, each with its own start period and pacing
    task automatic test_random_traffic();
        logic [7:0] setting;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       setting = 8'd255;
                1:       setting = 8'd1;
                2:       setting = 8'($urandom_range(0, 255));
                default: setting = 8'($urandom_range(0, 24));
            endcase
            write_ramp_start(setting);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            repeat (PHASE_REQUESTS) send_request(random_request());
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Check each taken result and pace the result stall
    always @(posedge clk) begin
        t_res want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no request pending: %p", out_res);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (out_res.served_motor !== want.served_motor) begin
                    $error("served_motor exp %0d got %0d", want.served_motor,
                           out_res.served_motor);
                    mismatches++;
                end
                if (out_res.coil_pattern !== want.coil_pattern) begin
                    $error("coil_pattern exp %h got %h", want.coil_pattern,
                           out_res.coil_pattern);
                    mismatches++;
                end
                if (out_res.coil_write !== want.coil_write) begin
                    $error("coil_write exp %0d got %0d", want.coil_write,
                           out_res.coil_write);
                    mismatches++;
                end
                if (out_res.coil_off !== want.coil_off) begin
                    $error("coil_off exp %0d got %0d", want.coil_off, out_res.coil_off);
                    mismatches++;
                end
                if (out_res.busy_res !== want.busy_res) begin
                    $error("busy_res exp %0d got %0d", want.busy_res, out_res.busy_res);
                    mismatches++;
                end
                if (out_res.position !== want.position) begin
                    $error("position exp %0d got %0d", want.position, out_res.position);
                    mismatches++;
                end
                if (out_res.steps_left !== want.steps_left) begin
                    $error("steps_left exp %0d got %0d", want.steps_left,
                           out_res.steps_left);
                    mismatches++;
                end
                if (out_res.coil_write === 1'b1)
                    coil_steps++;
            end
            stall_left = rx_steady ? 0 : $urandom_range(0, 11);
        end
        out_stall <= (stall_left > 0);
        if (stall_left > 0)
            stall_left--;
    end

    // Abort when neither side makes progress
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        clear_motor_table();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_accel_ramp();
        test_random_traffic();
        wait_idle();
        $display("checked %0d requests with %0d coil steps over %0d start periods",
                 requests_sent, coil_steps, settings_used);
        $display("covered idle coils, zero period, ramp-down, spare opcode, extremes");
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
